// ===== rtl/mlpq_pkg.sv =====
// Package with constants, codes and types of the multilevel priority ready queue.
`timescale 1ns / 1ps

package mlpq_pkg;

    localparam int LEVELS       = 5;
    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;

    localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = COUNT_W + 1;
    localparam int SLOTS   = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int PRIO_W  = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_PICK    = 2'd1,
        CMD_STEAL   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

// ===== rtl/multilevel_priority_ready_queue_core.sv =====
// Top level of the multilevel priority ready queue: per-level FIFOs, pick, steal, preemption.
`timescale 1ns / 1ps

// Keeps one FIFO of task ids for each priority level in a single slot memory
// (level 0 is best). Each beat on the slave stream is an enqueue, a pick of
// the best level's head or a steal of the worst level's tail, and gives exactly
// one beat on the master stream. A beat goes from an input register through
// the head/count update and slot memory access into the result register; the
// slot memory read is registered. One beat is taken every cycle while the
// master stream does not stall, and a result held by the master stream stalls
// the slave stream. The user must write the preemption enable register through
// the cfg channel only while no beat is in flight; the block does not enforce it.
module multilevel_priority_ready_queue_core
    import mlpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // task_id[7:0], task_prio[10:8], task_is_idle[11], was_preempted[12],
    // running_prio[15:13]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_task_id[7:0], task_found[8], resched_req[9],
    // requeue_running_front[10], status[12:11], zero[15:13]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [0:0]            i_cfg_data
);

    logic                    r_cfg_preempt;

    logic                    r_in_valid;
    logic [1:0]              r_cmd;
    logic [TASK_ID_BITS-1:0] r_task_id;
    logic [PRIO_W-1:0]       r_task_prio;
    logic                    r_is_idle;
    logic                    r_preempted;
    logic [PRIO_W-1:0]       r_run_prio;

    logic [HEAD_W-1:0]       r_heads  [LEVELS];
    logic [COUNT_W-1:0]      r_counts [LEVELS];
    logic [HEAD_W-1:0]       n_heads  [LEVELS];
    logic [COUNT_W-1:0]      n_counts [LEVELS];

    logic [TASK_ID_BITS-1:0] r_mem [SLOTS];
    logic [TASK_ID_BITS-1:0] r_rd_data;

    logic                    r_out_valid;
    logic                    r_found;
    logic                    r_resched;
    logic                    r_front;
    t_status                 r_status;

    logic                    n_found;
    logic                    n_resched;
    logic                    n_front;
    t_status                 n_status;

    logic                    wr_en;
    logic                    rd_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;

    logic                    advance;
    logic                    in_accept;

    logic [LEVELS-1:0]       nonempty;
    logic [LVL_W-1:0]        best_lvl;
    logic [LVL_W-1:0]        worst_lvl;
    logic [LVL_W-1:0]        enq_lvl;
    logic [SUM_W-1:0]        pos_sum;
    logic [HEAD_W-1:0]       pos;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [HEAD_W-1:0] p);
        slot_addr = ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    function automatic logic [HEAD_W-1:0] wrap_pos(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] w;
        w = (s >= SUM_W'(QUEUE_DEPTH)) ? s - SUM_W'(QUEUE_DEPTH) : s;
        wrap_pos = w[HEAD_W-1:0];
    endfunction

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_status, r_front, r_resched, r_found,
                            (r_found ? r_rd_data : TASK_ID_BITS'(0))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_preempt <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg_preempt <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd       <= s_axis_tuser;
            r_task_id   <= s_axis_tdata[7:0];
            r_task_prio <= s_axis_tdata[10:8];
            r_is_idle   <= s_axis_tdata[11];
            r_preempted <= s_axis_tdata[12];
            r_run_prio  <= s_axis_tdata[15:13];
        end
    end

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            nonempty[i] = (r_counts[i] != '0);
        end
        best_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                best_lvl = LVL_W'(i);
            end
        end
        worst_lvl = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (nonempty[i]) begin
                worst_lvl = LVL_W'(i);
            end
        end
    end

    always_comb begin
        n_heads   = r_heads;
        n_counts  = r_counts;
        n_found   = 1'b0;
        n_resched = 1'b0;
        n_front   = 1'b0;
        n_status  = ST_OK;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        wr_addr   = '0;
        rd_addr   = '0;
        enq_lvl   = r_task_prio[LVL_W-1:0];
        pos_sum   = '0;
        pos       = '0;
        case (r_cmd)
            CMD_ENQUEUE: begin
                if (r_is_idle) begin
                    n_status = ST_OK;
                end else if ({1'b0, r_task_prio} >= 4'(LEVELS)) begin
                    n_status = ST_RANGE;
                end else if (r_counts[enq_lvl] >= COUNT_W'(QUEUE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    pos_sum = SUM_W'(r_heads[enq_lvl]) + SUM_W'(r_counts[enq_lvl]);
                    pos     = wrap_pos(pos_sum);
                    wr_en   = 1'b1;
                    wr_addr = slot_addr(enq_lvl, pos);
                    n_counts[enq_lvl] = r_counts[enq_lvl] + COUNT_W'(1);
                    if (!r_preempted && r_cfg_preempt && (r_task_prio < r_run_prio)) begin
                        n_resched = 1'b1;
                        n_front   = 1'b1;
                    end
                end
            end
            CMD_PICK: begin
                if (|nonempty) begin
                    n_found = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = slot_addr(best_lvl, r_heads[best_lvl]);
                    n_heads[best_lvl] = (r_heads[best_lvl] == HEAD_W'(QUEUE_DEPTH - 1))
                                        ? '0 : r_heads[best_lvl] + HEAD_W'(1);
                    n_counts[best_lvl] = r_counts[best_lvl] - COUNT_W'(1);
                end
            end
            CMD_STEAL: begin
                if (|nonempty) begin
                    n_found = 1'b1;
                    rd_en   = 1'b1;
                    pos_sum = SUM_W'(r_heads[worst_lvl]) + SUM_W'(r_counts[worst_lvl])
                              - SUM_W'(1);
                    pos     = wrap_pos(pos_sum);
                    rd_addr = slot_addr(worst_lvl, pos);
                    n_counts[worst_lvl] = r_counts[worst_lvl] - COUNT_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_heads[i]  <= '0;
                r_counts[i] <= '0;
            end
        end else if (advance) begin
            r_heads  <= n_heads;
            r_counts <= n_counts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && wr_en) begin
            r_mem[wr_addr] <= r_task_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_found   <= n_found;
            r_resched <= n_resched;
            r_front   <= n_front;
            r_status  <= n_status;
        end
    end

endmodule
